FILE: rtl/twa_pkg.sv
// shared types, constants and saturation helpers for the window averager
// used by all modules of the time_block_window_averager core; no dependencies
`timescale 1ns / 1ps

package twa_pkg;

  // number of sample columns carried by one timestep request
  localparam int NUM_VALUES = 4;
  localparam int VI_W       = $clog2(NUM_VALUES);

  // iterative divider geometry
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;

  // configuration register indexes
  localparam logic [2:0] CFG_SAMPLE_EVERY  = 3'd0;
  localparam logic [2:0] CFG_REPEAT_COUNT  = 3'd1;
  localparam logic [2:0] CFG_OUTPUT_PERIOD = 3'd2;
  localparam logic [2:0] CFG_AVERAGE_MODE  = 3'd3;
  localparam logic [2:0] CFG_WINDOW_LENGTH = 3'd4;
  localparam logic [2:0] CFG_START_STEP    = 3'd5;
  localparam logic [2:0] CFG_HOLD_MASK     = 3'd6;

  // averaging modes
  localparam logic [1:0] MODE_RUNNING = 2'd1;
  localparam logic [1:0] MODE_WINDOW  = 2'd2;

  localparam logic signed [47:0] TOT_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] TOT_MIN = {1'b1, {47{1'b0}}};
  localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

  // datapath commands issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_DIV_T,
    OP_MUL_Q,
    OP_NV_ADD1,
    OP_DIV_D,
    OP_NV_ADD2,
    OP_SCHED_FIN,
    OP_SAMPLE,
    OP_DIV_B,
    OP_MEAN,
    OP_WPREP,
    OP_MEM_RD,
    OP_TOT,
    OP_COUNT,
    OP_MUL_H,
    OP_HOLD,
    OP_DIV_O,
    OP_OUT,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [VI_W-1:0] vi;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic hit;
    logic last_rep;
    logic below_start;
    logic div_done;
    logic out_busy;
  } status_t;

  // clamp a wide signed value to 48 bits
  function automatic logic signed [47:0] sat48(input logic signed [66:0] v);
    logic signed [47:0] r;
    if (v > 67'(TOT_MAX)) r = TOT_MAX;
    else if (v < 67'(TOT_MIN)) r = TOT_MIN;
    else r = v[47:0];
    return r;
  endfunction

  // clamp a signed quotient to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'(S32_MAX)) r = S32_MAX;
    else if (v < 49'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/twa_divider.sv
// restoring unsigned divider, one quotient bit per cycle
// uses twa_pkg for its operand widths
`timescale 1ns / 1ps

module twa_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [twa_pkg::DIV_NW-1:0] dividend_i,
  input  logic [twa_pkg::DIV_DW-1:0] divisor_i,
  output logic [twa_pkg::DIV_NW-1:0] quotient_o,
  output logic                       done_o
);

  localparam int NW    = twa_pkg::DIV_NW;
  localparam int DW    = twa_pkg::DIV_DW;
  localparam int CNT_W = $clog2(NW);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q, dvs_q;
  logic [NW-1:0]    quo_q;
  logic [DW:0]      shifted, rem_n;
  logic             ge;

  // one trial subtraction
  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_n   = ge ? (shifted - {1'b0, dvs_q}) : shifted;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(NW - 1));
      if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NW - 1)) busy_q <= 1'b0;
      end
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

FILE: rtl/twa_ctrl.sv
// sequencing state machine for the window averager
// uses twa_pkg command and status types
`timescale 1ns / 1ps

module twa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  twa_pkg::status_t status_i,
  output twa_pkg::cmd_t    cmd_o
);

  typedef enum logic [20:0] {
    ST_IDLE  = 21'h000001,
    ST_DIVT  = 21'h000002,
    ST_WDT   = 21'h000004,
    ST_ADD1  = 21'h000008,
    ST_CMP   = 21'h000010,
    ST_DIVD  = 21'h000020,
    ST_WDD   = 21'h000040,
    ST_ADD2  = 21'h000080,
    ST_FIN   = 21'h000100,
    ST_CHECK = 21'h000200,
    ST_DIVB  = 21'h000400,
    ST_WDB   = 21'h000800,
    ST_WPREP = 21'h001000,
    ST_MRD   = 21'h002000,
    ST_TOT   = 21'h004000,
    ST_COUNT = 21'h008000,
    ST_MULH  = 21'h010000,
    ST_HOLD  = 21'h020000,
    ST_DIVO  = 21'h040000,
    ST_WDO   = 21'h080000,
    ST_EMIT  = 21'h100000
  } state_e;

  localparam int VI_W = twa_pkg::VI_W;

  state_e          state_q, state_d;
  logic [VI_W-1:0] vi_q, vi_d;
  logic            vi_last;

  assign vi_last    = vi_q == VI_W'(twa_pkg::NUM_VALUES - 1);
  assign in_ready_o = state_q == ST_IDLE;

  // next state and command
  always_comb begin
    state_d   = state_q;
    vi_d      = vi_q;
    cmd_o.op  = twa_pkg::OP_NONE;
    cmd_o.vi  = vi_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = twa_pkg::OP_LATCH;
          state_d  = status_i.started ? ST_CHECK : ST_DIVT;
        end
      end
      ST_DIVT: begin
        cmd_o.op = twa_pkg::OP_DIV_T;
        state_d  = ST_WDT;
      end
      ST_WDT: begin
        if (status_i.div_done) begin
          cmd_o.op = twa_pkg::OP_MUL_Q;
          state_d  = ST_ADD1;
        end
      end
      ST_ADD1: begin
        cmd_o.op = twa_pkg::OP_NV_ADD1;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        state_d = status_i.below_start ? ST_DIVD : ST_FIN;
      end
      ST_DIVD: begin
        cmd_o.op = twa_pkg::OP_DIV_D;
        state_d  = ST_WDD;
      end
      ST_WDD: begin
        if (status_i.div_done) begin
          cmd_o.op = twa_pkg::OP_MUL_Q;
          state_d  = ST_ADD2;
        end
      end
      ST_ADD2: begin
        cmd_o.op = twa_pkg::OP_NV_ADD2;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.op = twa_pkg::OP_SCHED_FIN;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        vi_d = '0;
        if (status_i.hit) begin
          cmd_o.op = twa_pkg::OP_SAMPLE;
          state_d  = status_i.last_rep ? ST_DIVB : ST_IDLE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIVB: begin
        cmd_o.op = twa_pkg::OP_DIV_B;
        state_d  = ST_WDB;
      end
      ST_WDB: begin
        if (status_i.div_done) begin
          cmd_o.op = twa_pkg::OP_MEAN;
          if (vi_last) begin
            vi_d    = '0;
            state_d = ST_WPREP;
          end else begin
            vi_d    = vi_q + VI_W'(1);
            state_d = ST_DIVB;
          end
        end
      end
      ST_WPREP: begin
        cmd_o.op = twa_pkg::OP_WPREP;
        state_d  = ST_MRD;
      end
      ST_MRD: begin
        cmd_o.op = twa_pkg::OP_MEM_RD;
        state_d  = ST_TOT;
      end
      ST_TOT: begin
        cmd_o.op = twa_pkg::OP_TOT;
        if (vi_last) begin
          vi_d    = '0;
          state_d = ST_COUNT;
        end else begin
          vi_d    = vi_q + VI_W'(1);
          state_d = ST_MRD;
        end
      end
      ST_COUNT: begin
        cmd_o.op = twa_pkg::OP_COUNT;
        state_d  = ST_MULH;
      end
      ST_MULH: begin
        cmd_o.op = twa_pkg::OP_MUL_H;
        state_d  = ST_HOLD;
      end
      ST_HOLD: begin
        cmd_o.op = twa_pkg::OP_HOLD;
        state_d  = ST_DIVO;
      end
      ST_DIVO: begin
        cmd_o.op = twa_pkg::OP_DIV_O;
        state_d  = ST_WDO;
      end
      ST_WDO: begin
        if (status_i.div_done) begin
          cmd_o.op = twa_pkg::OP_OUT;
          if (vi_last) begin
            vi_d    = '0;
            state_d = ST_EMIT;
          end else begin
            vi_d    = vi_q + VI_W'(1);
            state_d = ST_MULH;
          end
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = twa_pkg::OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vi_q    <= '0;
    end else begin
      state_q <= state_d;
      vi_q    <= vi_d;
    end
  end

endmodule

FILE: rtl/twa_datapath.sv
// registers, schedule arithmetic, sums, window store and output register
// uses twa_pkg and instantiates twa_divider
`timescale 1ns / 1ps

module twa_datapath #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [31:0]         timestep_i,
  input  logic signed [31:0]  sample_i [twa_pkg::NUM_VALUES],
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [31:0]         out_step_o,
  output logic signed [31:0]  out_mean_o [twa_pkg::NUM_VALUES],
  input  twa_pkg::cmd_t       cmd_i,
  output twa_pkg::status_t    status_o
);

  localparam int NV    = twa_pkg::NUM_VALUES;
  localparam int DEPTH = WINDOW_MAX * NV;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(WINDOW_MAX + 1);

  // configuration
  logic [15:0] se_q;
  logic [7:0]  nrep_q;
  logic [23:0] per_q;
  logic [1:0]  mode_q;
  logic [4:0]  wl_q;
  logic [31:0] start_q;
  logic [3:0]  hm_q;

  // block state
  logic signed [39:0] bs_q   [NV];
  logic signed [47:0] tot_q  [NV];
  logic signed [31:0] mean_q [NV];
  logic signed [31:0] res_q  [NV];
  logic signed [31:0] smp_q  [NV];
  logic [7:0]         ri_q;
  logic [CW-1:0]      wi_q;
  logic               full_q;
  logic [31:0]        cnt_q;
  logic [31:0]        nss_q;
  logic               started_q;
  logic [31:0]        t_q;
  logic [23:0]        back_q;
  logic signed [34:0] nv_q;
  logic signed [66:0] prod_q;
  logic               neg_q;
  logic signed [31:0] rd_q;
  logic               out_valid_q;
  logic [31:0]        out_step_q;
  logic signed [31:0] out_mean_q [NV];
  logic signed [31:0] wmem [DEPTH];

  // effective register values
  logic [15:0]   se_eff;
  logic [7:0]    nrep_eff;
  logic [23:0]   nf;
  logic [CW-1:0] nw;
  logic [31:0]   n_eff;
  logic          held;
  logic [AW-1:0] addr;

  assign se_eff   = (se_q == '0) ? 16'd1 : se_q;
  assign nrep_eff = (nrep_q == '0) ? 8'd1 : nrep_q;
  assign nf       = (per_q == '0) ? 24'd1 : per_q;
  assign n_eff    = (cnt_q == '0) ? 32'd1 : cnt_q;
  assign held     = hm_q[cmd_i.vi];
  assign addr     = AW'(32'(wi_q) * NV + 32'(cmd_i.vi));

  always_comb begin
    if (wl_q == '0) nw = CW'(1);
    else if (32'(wl_q) > WINDOW_MAX) nw = CW'(WINDOW_MAX);
    else nw = CW'(wl_q);
  end

  // divider operand selection
  logic                       div_start, div_done;
  logic [twa_pkg::DIV_NW-1:0] div_num, quo;
  logic [twa_pkg::DIV_DW-1:0] div_den;
  logic                       div_neg;
  logic signed [34:0]         d_val;
  logic signed [40:0]         bx, bx_abs;
  logic signed [48:0]         tx, tx_abs;
  logic signed [48:0]         qs;

  always_comb begin
    d_val  = $signed({3'b0, start_q}) - nv_q + $signed({11'b0, nf}) - 35'sd1;
    bx     = {bs_q[cmd_i.vi][39], bs_q[cmd_i.vi]};
    bx_abs = bx[40] ? -bx : bx;
    tx     = {tot_q[cmd_i.vi][47], tot_q[cmd_i.vi]};
    tx_abs = tx[48] ? -tx : tx;
    div_start = 1'b0;
    div_num   = 48'(t_q);
    div_den   = 32'(nf);
    div_neg   = 1'b0;
    unique case (cmd_i.op)
      twa_pkg::OP_DIV_T: div_start = 1'b1;
      twa_pkg::OP_DIV_D: begin
        div_start = 1'b1;
        div_num   = {14'b0, d_val[33:0]};
      end
      twa_pkg::OP_DIV_B: begin
        div_start = 1'b1;
        div_num   = {8'b0, bx_abs[39:0]};
        div_den   = 32'(nrep_eff);
        div_neg   = bx[40];
      end
      twa_pkg::OP_DIV_O: begin
        div_start = 1'b1;
        div_num   = tx_abs[47:0];
        div_den   = n_eff;
        div_neg   = tx[48];
      end
      default: ;
    endcase
    qs = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  twa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // shared multiplier operands
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  always_comb begin
    if (cmd_i.op == twa_pkg::OP_MUL_H) begin
      mul_a = 34'(mean_q[cmd_i.vi]);
      mul_b = $signed({1'b0, n_eff});
    end else begin
      mul_a = $signed({1'b0, quo[32:0]});
      mul_b = $signed({9'b0, nf});
    end
  end

  // first schedule final adjustment
  logic signed [35:0] nv36, t36, nf36, fa0, fa;
  always_comb begin
    nv36 = 36'(nv_q);
    t36  = $signed({4'b0, t_q});
    nf36 = $signed({12'b0, nf});
    if ((nv36 - nf36 == t36) && (nrep_eff == 8'd1)) fa0 = t36;
    else fa0 = nv36 - $signed({12'b0, back_q});
    fa = (fa0 < t36) ? fa0 + nf36 : fa0;
  end

  // window total before saturation
  logic signed [49:0] tv;
  always_comb begin
    tv = 50'(tot_q[cmd_i.vi]) + 50'(mean_q[cmd_i.vi]);
    if (full_q) tv = tv - 50'(rd_q);
  end

  logic [8:0]    ri_inc;
  logic [CW:0]   wi_inc;
  assign ri_inc = {1'b0, ri_q} + 9'd1;
  assign wi_inc = {1'b0, wi_q} + (CW + 1)'(1);

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      se_q        <= 16'd1;
      nrep_q      <= 8'd1;
      per_q       <= 24'd1;
      mode_q      <= '0;
      wl_q        <= 5'd1;
      start_q     <= '0;
      hm_q        <= '0;
      ri_q        <= '0;
      wi_q        <= '0;
      full_q      <= 1'b0;
      cnt_q       <= '0;
      nss_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NV; i++) begin
        bs_q[i]  <= '0;
        tot_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          twa_pkg::CFG_SAMPLE_EVERY:  se_q    <= cfg_data_i[15:0];
          twa_pkg::CFG_REPEAT_COUNT:  nrep_q  <= cfg_data_i[7:0];
          twa_pkg::CFG_OUTPUT_PERIOD: per_q   <= cfg_data_i[23:0];
          twa_pkg::CFG_AVERAGE_MODE:  mode_q  <= cfg_data_i[1:0];
          twa_pkg::CFG_WINDOW_LENGTH: wl_q    <= cfg_data_i[4:0];
          twa_pkg::CFG_START_STEP:    start_q <= cfg_data_i;
          twa_pkg::CFG_HOLD_MASK:     hm_q    <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (cmd_i.op)
        twa_pkg::OP_SCHED_FIN: begin
          nss_q     <= fa[31:0];
          started_q <= 1'b1;
        end
        twa_pkg::OP_SAMPLE: begin
          for (int i = 0; i < NV; i++) begin
            if (hm_q[i]) bs_q[i] <= 40'(smp_q[i]);
            else if (ri_q == '0) bs_q[i] <= 40'(smp_q[i]);
            else bs_q[i] <= bs_q[i] + 40'(smp_q[i]);
          end
          if (ri_inc >= {1'b0, nrep_eff}) begin
            ri_q  <= '0;
            nss_q <= t_q + 32'(nf) - 32'(back_q);
          end else begin
            ri_q  <= ri_inc[7:0];
            nss_q <= nss_q + 32'(se_eff);
          end
        end
        twa_pkg::OP_WPREP: begin
          if (mode_q == twa_pkg::MODE_WINDOW && wi_q >= nw) wi_q <= '0;
        end
        twa_pkg::OP_TOT: begin
          if (mode_q == twa_pkg::MODE_RUNNING)
            tot_q[cmd_i.vi] <= twa_pkg::sat48(67'(tot_q[cmd_i.vi]) + 67'(mean_q[cmd_i.vi]));
          else if (mode_q == twa_pkg::MODE_WINDOW)
            tot_q[cmd_i.vi] <= twa_pkg::sat48(67'(tv));
          else
            tot_q[cmd_i.vi] <= 48'(mean_q[cmd_i.vi]);
        end
        twa_pkg::OP_COUNT: begin
          if (mode_q == twa_pkg::MODE_RUNNING) begin
            if (cnt_q != '1) cnt_q <= cnt_q + 32'd1;
          end else if (mode_q == twa_pkg::MODE_WINDOW) begin
            if (wi_inc >= {1'b0, nw}) begin
              wi_q   <= '0;
              full_q <= 1'b1;
              cnt_q  <= 32'(nw);
            end else begin
              wi_q  <= wi_inc[CW-1:0];
              cnt_q <= full_q ? 32'(nw) : 32'(wi_inc);
            end
          end else begin
            cnt_q <= 32'd1;
          end
        end
        twa_pkg::OP_HOLD: begin
          if (held) tot_q[cmd_i.vi] <= twa_pkg::sat48(prod_q);
        end
        twa_pkg::OP_EMIT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    back_q <= 24'(nrep_eff - 8'd1) * 24'(se_eff);
    if (div_start) neg_q <= div_neg;
    unique case (cmd_i.op)
      twa_pkg::OP_LATCH: begin
        t_q <= timestep_i;
        for (int i = 0; i < NV; i++) smp_q[i] <= sample_i[i];
      end
      twa_pkg::OP_MUL_Q, twa_pkg::OP_MUL_H: prod_q <= 67'(mul_a) * 67'(mul_b);
      twa_pkg::OP_NV_ADD1: nv_q <= prod_q[34:0] + $signed({11'b0, nf});
      twa_pkg::OP_NV_ADD2: nv_q <= nv_q + prod_q[34:0];
      twa_pkg::OP_MEAN: begin
        mean_q[cmd_i.vi] <= held ? bs_q[cmd_i.vi][31:0] : twa_pkg::sat32(qs);
      end
      twa_pkg::OP_OUT: res_q[cmd_i.vi] <= twa_pkg::sat32(qs);
      twa_pkg::OP_EMIT: begin
        out_step_q <= t_q;
        for (int i = 0; i < NV; i++) out_mean_q[i] <= res_q[i];
      end
      default: ;
    endcase
  end

  // window store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == twa_pkg::OP_MEM_RD) rd_q <= wmem[addr];
    if (cmd_i.op == twa_pkg::OP_TOT && mode_q == twa_pkg::MODE_WINDOW)
      wmem[addr] <= mean_q[cmd_i.vi];
  end

  // status to the controller
  always_comb begin
    status_o.started     = started_q;
    status_o.hit         = t_q == nss_q;
    status_o.last_rep    = ri_inc >= {1'b0, nrep_eff};
    status_o.below_start = nv_q < $signed({3'b0, start_q});
    status_o.div_done    = div_done;
    status_o.out_busy    = out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_step_o  = out_step_q;
  assign out_mean_o  = out_mean_q;

endmodule

FILE: rtl/time_block_window_averager_core.sv
// Time block window averager top level: controller, datapath and divider.
// A tick off the sampling schedule passes through the check state only; a sampled tick also sums.
// The first tick also runs the schedule divisions.
// A block end runs the shared 48-bit divider eight times: once per column for means and outputs.
// Results wait in an output register; inputs are taken again while one waits.
// Reset (async, active low) restores register defaults; the window store is not cleared.
`timescale 1ns / 1ps

module time_block_window_averager_core #(
  parameter int WINDOW_MAX = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        timestep_i,
  input  logic signed [31:0] sample_0_i,
  input  logic signed [31:0] sample_1_i,
  input  logic signed [31:0] sample_2_i,
  input  logic signed [31:0] sample_3_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        out_step_o,
  output logic signed [31:0] mean_0_o,
  output logic signed [31:0] mean_1_o,
  output logic signed [31:0] mean_2_o,
  output logic signed [31:0] mean_3_o
);

  twa_pkg::cmd_t      cmd;
  twa_pkg::status_t   status;
  logic signed [31:0] samples [twa_pkg::NUM_VALUES];
  logic signed [31:0] means   [twa_pkg::NUM_VALUES];

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;

  // sequencing
  twa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  twa_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .timestep_i  (timestep_i),
    .sample_i    (samples),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_step_o  (out_step_o),
    .out_mean_o  (means),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  assign mean_0_o = means[0];
  assign mean_1_o = means[1];
  assign mean_2_o = means[2];
  assign mean_3_o = means[3];

endmodule

FILE: dv/tb.sv
// testbench for time_block_window_averager_core: directed table plus random phases
// checks random-phase results against an in-bench schedule and averaging predictor; needs twa_pkg
`timescale 1ns / 1ps

module tb;

  localparam int  NV        = 4;
  localparam int  WMAX      = 16;
  localparam int  DRAIN     = 600;
  localparam int  CYC_LIMIT = 5000000;
  localparam int  SQUEEZE   = 3000;
  localparam int  PHASES    = 14;

  typedef struct packed {
    logic [31:0]           step;
    logic [NV-1:0][31:0]   m;
  } avg_t;

  typedef struct {
    bit               hit;
    logic [31:0]      s[NV];
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        t_in = '0;
  logic [31:0]        s_in[NV];
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        out_step;
  logic signed [31:0] mean_o[NV];

  avg_t        avg_q[$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int unsigned cyc = 0;
  bit          squeeze_req = 1'b0;

  // block configuration copy
  int unsigned c_se, c_rc, c_op, c_mode, c_wl, c_start, c_hold;
  // block state copy
  longint      blk_sum[NV], tot[NV], win[WMAX*NV];
  bit          win_wr[WMAX];
  int unsigned rep_idx, win_idx, avg_cnt, next_step;
  bit          win_full, run_started;

  initial for (int i = 0; i < NV; i++) s_in[i] = '0;

  always #5 clk = ~clk;

  time_block_window_averager_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .timestep_i(t_in),
    .sample_0_i(s_in[0]), .sample_1_i(s_in[1]), .sample_2_i(s_in[2]), .sample_3_i(s_in[3]),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_step_o(out_step),
    .mean_0_o(mean_o[0]), .mean_1_o(mean_o[1]), .mean_2_o(mean_o[2]), .mean_3_o(mean_o[3])
  );

  function automatic int unsigned eff(int unsigned r);
    return (r != 0) ? r : 1;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > longint'(twa_pkg::TOT_MAX)) return longint'(twa_pkg::TOT_MAX);
    if (v < longint'(twa_pkg::TOT_MIN)) return longint'(twa_pkg::TOT_MIN);
    return v;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // first sampling step from the first tick
  function automatic int unsigned first_sample_step(int unsigned t);
    longint nf, back, tt, nv;
    nf   = eff(c_op);
    back = longint'(eff(c_rc) - 1) * longint'(eff(c_se));
    tt   = t;
    nv   = (tt / nf) * nf + nf;
    if (nv < longint'(c_start)) nv += ((longint'(c_start) - nv + nf - 1) / nf) * nf;
    if (nv - nf == tt && eff(c_rc) == 1) nv = tt;
    else nv -= back;
    if (nv < tt) nv += nf;
    return nv[31:0];
  endfunction

  // advance the averager by one tick; returns 1 when an average is due
  function automatic bit average_tick(input logic [31:0] t, input logic [31:0] s[NV],
                                      output avg_t res);
    int unsigned nrep, nw, slot;
    longint      mean[NV];
    longint      sv, v, n, q;
    bit          held;
    res  = '0;
    nrep = eff(c_rc);
    nw   = c_wl;
    if (!run_started) begin
      run_started = 1'b1;
      next_step   = first_sample_step(t);
    end
    if (t != next_step) return 1'b0;
    for (int i = 0; i < NV; i++) begin
      sv   = longint'(signed'(s[i]));
      held = c_hold[i];
      if (rep_idx == 0) blk_sum[i] = 0;
      if (held) blk_sum[i] = sv;
      else blk_sum[i] += sv;
    end
    rep_idx++;
    if (rep_idx < nrep) begin
      next_step += eff(c_se);
      return 1'b0;
    end
    rep_idx   = 0;
    next_step = t + eff(c_op) - (nrep - 1) * eff(c_se);
    for (int i = 0; i < NV; i++)
      mean[i] = c_hold[i] ? blk_sum[i] : clamp32(blk_sum[i] / longint'(nrep));
    if (nw < 1) nw = 1;
    if (nw > WMAX) nw = WMAX;
    if (c_mode == twa_pkg::MODE_RUNNING) begin
      for (int i = 0; i < NV; i++) tot[i] = clamp48(tot[i] + mean[i]);
      if (avg_cnt != 32'hFFFF_FFFF) avg_cnt++;
    end else if (c_mode == twa_pkg::MODE_WINDOW) begin
      if (win_idx >= nw) win_idx = 0;
      for (int i = 0; i < NV; i++) begin
        slot = win_idx * NV + i;
        v    = tot[i] + mean[i];
        if (win_full) v -= win[slot];
        tot[i]    = clamp48(v);
        win[slot] = mean[i];
      end
      win_wr[win_idx] = 1'b1;
      win_idx++;
      if (win_idx >= nw) begin
        win_idx  = 0;
        win_full = 1'b1;
      end
      avg_cnt = win_full ? nw : win_idx;
    end else begin
      for (int i = 0; i < NV; i++) tot[i] = mean[i];
      avg_cnt = 1;
    end
    res.step = t;
    n = eff(avg_cnt);
    for (int i = 0; i < NV; i++) begin
      if (c_hold[i]) begin
        q = longint'(twa_pkg::TOT_MAX) / n;
        if (mean[i] > q) tot[i] = longint'(twa_pkg::TOT_MAX);
        else if (mean[i] < -q) tot[i] = longint'(twa_pkg::TOT_MIN);
        else tot[i] = mean[i] * n;
      end
      v = clamp32(tot[i] / n);
      res.m[i] = v[31:0];
    end
    return 1'b1;
  endfunction

  // one register write, held for a single edge by the caller's sequence
  task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      twa_pkg::CFG_SAMPLE_EVERY:  c_se    = val & 32'hFFFF;
      twa_pkg::CFG_REPEAT_COUNT:  c_rc    = val & 32'hFF;
      twa_pkg::CFG_OUTPUT_PERIOD: c_op    = val & 32'hFF_FFFF;
      twa_pkg::CFG_AVERAGE_MODE:  c_mode  = val & 32'h3;
      twa_pkg::CFG_WINDOW_LENGTH: c_wl    = val & 32'h1F;
      twa_pkg::CFG_START_STEP:    c_start = val;
      twa_pkg::CFG_HOLD_MASK:     c_hold  = val & 32'hF;
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // a window length that never reads a slot left unwritten
  function automatic int unsigned safe_window(int unsigned want);
    int unsigned nw;
    nw = (want < 1) ? 1 : (want > WMAX ? WMAX : want);
    if (win_full)
      for (int i = 0; i < nw; i++) if (!win_wr[i]) return c_wl;
    return want;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  // drive one tick request and queue any average it is expected to produce
  task automatic send_tick(input logic [31:0] t, input logic [31:0] s[NV],
                           input bit typed_hit, input bit use_typed);
    avg_t res, typed;
    bit   hit;
    int   gap;
    t_in = t;
    for (int i = 0; i < NV; i++) s_in[i] = s[i];
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    n_items++;
    hit = average_tick(t, s, res);
    if (use_typed) begin
      typed.step = t;
      for (int i = 0; i < NV; i++) typed.m[i] = s[i];
      if (typed_hit) avg_q.push_back(typed);
    end else if (hit) begin
      avg_q.push_back(res);
    end
    @(negedge clk);
    gap = 0;
    if ($urandom_range(0, 4) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    while (avg_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // receiver: random back-pressure plus one long hold-off
  initial begin
    int gap_left;
    bit squeezed;
    gap_left = 0;
    squeezed = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        out_ready = 1'b0;
        repeat (SQUEEZE - 1) @(negedge clk);
      end else if (gap_left > 0) begin
        out_ready = 1'b0;
        gap_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 5) == 0)
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    avg_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (avg_q.size() == 0) begin
        $error("unexpected result at step %h", out_step);
        errors++;
      end else begin
        want = avg_q.pop_front();
        if (out_step !== want.step) begin
          $error("out_step expected %h actual %h", want.step, out_step);
          errors++;
        end
        for (int i = 0; i < NV; i++)
          if (mean_o[i] !== want.m[i]) begin
            $error("mean_%0d expected %h actual %h", i, want.m[i], mean_o[i]);
            errors++;
          end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    row_t        rows[12];
    logic [31:0] smp[NV];
    logic [31:0] t;
    int unsigned se, rc, k, items;

    c_se = 1; c_rc = 1; c_op = 1; c_mode = 0; c_wl = 1; c_start = 0; c_hold = 0;
    for (int i = 0; i < NV; i++) begin
      blk_sum[i] = 0;
      tot[i] = 0;
    end
    for (int i = 0; i < WMAX*NV; i++) win[i] = 0;
    for (int i = 0; i < WMAX; i++) win_wr[i] = 1'b0;
    rep_idx = 0; win_idx = 0; avg_cnt = 0; next_step = 0;
    win_full = 1'b0; run_started = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: defaults, start step five ticks on, steps wrap through zero
    t = 32'hFFFF_FFF8;
    cfg_write(twa_pkg::CFG_START_STEP, t + 5);
    cfg_done();
    for (int r = 0; r < 12; r++) begin
      rows[r].hit = (r >= 5);
      for (int i = 0; i < NV; i++) rows[r].s[i] = $urandom;
    end
    rows[5].s  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    rows[6].s  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
    rows[7].s  = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'h5555_AAAA};
    rows[8].s  = '{32'hAAAA_5555, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    for (int r = 0; r < 12; r++) begin
      send_tick(t, rows[r].s, rows[r].hit, 1'b1);
      t++;
    end
    in_valid = 1'b0;

    for (int ph = 1; ph <= PHASES; ph++) begin
      wait_idle();
      se = $urandom_range(1, 3);
      rc = $urandom_range(1, 5);
      k  = rc + $urandom_range(0, 3);
      items = 50 + 3 * se * k;
      case (ph)
        1: begin
          cfg_write(twa_pkg::CFG_SAMPLE_EVERY, 16'hFFFF);
          cfg_write(twa_pkg::CFG_REPEAT_COUNT, 1);
          cfg_write(twa_pkg::CFG_OUTPUT_PERIOD, 2);
          cfg_write(twa_pkg::CFG_AVERAGE_MODE, 3);
          cfg_write(twa_pkg::CFG_HOLD_MASK, 4'hF);
        end
        2: begin
          cfg_write(twa_pkg::CFG_SAMPLE_EVERY, 1);
          cfg_write(twa_pkg::CFG_REPEAT_COUNT, 8'hFF);
          cfg_write(twa_pkg::CFG_OUTPUT_PERIOD, 255);
          cfg_write(twa_pkg::CFG_AVERAGE_MODE, twa_pkg::MODE_RUNNING);
          cfg_write(twa_pkg::CFG_HOLD_MASK, 4'h5);
          items = 300;
        end
        3: begin
          cfg_write(twa_pkg::CFG_SAMPLE_EVERY, 0);
          cfg_write(twa_pkg::CFG_REPEAT_COUNT, 0);
          cfg_write(twa_pkg::CFG_OUTPUT_PERIOD, 0);
          cfg_write(twa_pkg::CFG_AVERAGE_MODE, twa_pkg::MODE_WINDOW);
          cfg_write(twa_pkg::CFG_WINDOW_LENGTH, safe_window(0));
          cfg_write(twa_pkg::CFG_HOLD_MASK, 0);
        end
        5: begin
          // every tick an average: back-pressure fills the block
          cfg_write(twa_pkg::CFG_SAMPLE_EVERY, 1);
          cfg_write(twa_pkg::CFG_REPEAT_COUNT, 1);
          cfg_write(twa_pkg::CFG_OUTPUT_PERIOD, 1);
          cfg_write(twa_pkg::CFG_AVERAGE_MODE, $urandom_range(0, 3));
          cfg_write(twa_pkg::CFG_HOLD_MASK, $urandom_range(0, 15));
          squeeze_req = 1'b1;
        end
        default: begin
          if (ph == 4) begin
            cfg_write(twa_pkg::CFG_OUTPUT_PERIOD, 24'hFF_FFFF);
            cfg_write(twa_pkg::CFG_START_STEP, 32'hFFFF_FFFF);
          end
          cfg_write(twa_pkg::CFG_SAMPLE_EVERY, se);
          cfg_write(twa_pkg::CFG_REPEAT_COUNT, rc);
          cfg_write(twa_pkg::CFG_OUTPUT_PERIOD, se * k);
          cfg_write(twa_pkg::CFG_AVERAGE_MODE,
                    (ph % 2 == 0) ? twa_pkg::MODE_WINDOW : $urandom_range(0, 3));
          cfg_write(twa_pkg::CFG_WINDOW_LENGTH,
                    safe_window((ph == 6) ? WMAX : $urandom_range(1, WMAX)));
          cfg_write(twa_pkg::CFG_HOLD_MASK, $urandom_range(0, 15));
        end
      endcase
      cfg_done();
      for (int n = 0; n < items; n++) begin
        for (int i = 0; i < NV; i++) smp[i] = rand_sample();
        send_tick(t, smp, 1'b0, 1'b0);
        t++;
      end
      in_valid = 1'b0;
    end

    wait_idle();
    $display("covered %0d ticks and %0d averages over %0d settings", n_items, n_results,
             PHASES + 1);
    $display("modes one-block, running and window, held columns, step wrap and stalls");
    if (errors == 0 && avg_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
